// ===== sv/curvature_turn_segmenter_unit_defines.svh =====
// Assertion helpers for the turn segmenter checker.
`ifndef CURVATURE_TURN_SEGMENTER_UNIT_DEFINES_SVH
`define CURVATURE_TURN_SEGMENTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cts_pkg.sv =====
package cts_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CfgW      = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] REG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RUN_THRESHOLD  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SHARP_ANGLE    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_WIDE_ANGLE     = 2'd3;

  localparam logic [CfgW-1:0] PEAK_THRESHOLD_RST = 15'd410;
  localparam logic [CfgW-1:0] RUN_THRESHOLD_RST  = 15'd164;
  localparam logic [CfgW-1:0] SHARP_ANGLE_RST    = 15'd17157;
  localparam logic [CfgW-1:0] WIDE_ANGLE_RST     = 15'd8579;

  localparam logic [1:0] KIND_WIDE     = 2'd0;
  localparam logic [1:0] KIND_NORMAL   = 2'd1;
  localparam logic [1:0] KIND_SHARP    = 2'd2;
  localparam logic [1:0] KIND_STRAIGHT = 2'd3;

  localparam logic signed [17:0] HalfTurn = 18'sd25736;
  localparam logic signed [17:0] FullTurn = 18'sd51472;

  typedef struct packed {
    logic signed [15:0] curvature;
    logic signed [15:0] heading;
    logic [23:0]        arc_length;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         segment_kind;
    logic [IdxW-1:0]    start_index;
    logic [IdxW-1:0]    end_index;
    logic [23:0]        start_station;
    logic [23:0]        end_station;
    logic signed [15:0] peak_curvature;
    logic               last_of_step;
  } out_item_t;

  function automatic logic [14:0] mag15(input logic signed [15:0] k);
    logic [15:0] neg;
    neg = -k;
    if (k == -16'sd32768) begin
      return 15'h7FFF;
    end else if (k < 0) begin
      return neg[14:0];
    end else begin
      return k[14:0];
    end
  endfunction

endpackage

// ===== sv/curvature_turn_segmenter_unit.sv =====
// Turn/straight segmenter: takes one path point per cycle and emits turn and straight
// segments. A point that closes a turn yields up to three segments (leading straight,
// turn, and on the last point a trailing straight); the segments of one point go as one
// bundle into a four-entry queue and leave one per cycle while out_stall_i is low; the
// output drains a bundle segment by segment. The input stalls only while the
// queue is full. Configuration writes take effect at once and belong between paths.
module curvature_turn_segmenter_unit import cts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  typedef struct packed {
    out_item_t [2:0] seg;
    logic [1:0]      cnt;
  } bundle_t;

  logic [CfgW-1:0] peak_thr_q, run_thr_q, sharp_q, wide_q;

  logic [IdxW-1:0]    point_cnt_q, point_cnt_d;
  logic signed [15:0] prior_curv_q, prior_curv_d;
  logic [14:0]        older_mag_q, older_mag_d;
  logic signed [15:0] prior_head_q, prior_head_d;
  logic [23:0]        prior_st_q, prior_st_d;
  logic               run_active_q, run_active_d;
  logic               has_peak_q, has_peak_d;
  logic [IdxW-1:0]    rs_idx_q, rs_idx_d;
  logic signed [15:0] rs_head_q, rs_head_d;
  logic [23:0]        rs_st_q, rs_st_d;
  logic signed [15:0] best_q, best_d;
  logic [IdxW-1:0]    ss_idx_q, ss_idx_d;
  logic [23:0]        ss_st_q, ss_st_d;
  logic               turn_seen_q, turn_seen_d;

  bundle_t            q_mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     fill_q, fill_d;
  logic [1:0]         sub_q, sub_d;

  logic               in_acc, fin, push, pop, out_acc, out_last;
  logic [14:0]        mag, pmag;
  logic [IdxW-1:0]    idx;
  logic               peak_hit, has_peak1, close_early, close_any, open_run;
  logic               emit_lead, emit_turn, emit_trail;
  logic signed [15:0] best1;
  logic [IdxW-1:0]    end_idx, ss_idx2;
  logic signed [15:0] end_head;
  logic [23:0]        end_st, ss_st2;
  logic               turn_seen2;
  logic signed [17:0] d0, d1, d2, d3, d4;
  logic [17:0]        ad;
  logic [1:0]         turn_kind;
  out_item_t          lead_seg, turn_seg, trail_seg;
  bundle_t            slot_d, head;
  logic [1:0]         n;

  assign in_acc = in_valid_i & ~in_stall_o;
  assign fin    = in_data_i.final_point;
  assign mag    = mag15(in_data_i.curvature);
  assign pmag   = mag15(prior_curv_q);
  assign idx    = point_cnt_q;

  assign peak_hit = (idx >= IdxW'(2)) & run_active_q & (pmag > peak_thr_q) &
                    (pmag > older_mag_q) & (pmag > mag);
  assign best1 = (peak_hit & (~has_peak_q | (pmag > mag15(best_q)))) ? prior_curv_q : best_q;
  assign has_peak1   = has_peak_q | peak_hit;
  assign close_early = run_active_q & (mag <= run_thr_q);
  assign close_any   = close_early | (fin & run_active_q);
  assign open_run    = ~run_active_q & (mag > run_thr_q);
  assign emit_turn   = close_any & has_peak1;
  assign emit_lead   = emit_turn & (rs_idx_q > ss_idx_q);

  assign end_idx  = close_early ? idx - IdxW'(1) : idx;
  assign end_head = close_early ? prior_head_q : in_data_i.heading;
  assign end_st   = close_early ? prior_st_q : in_data_i.arc_length;

  assign ss_idx2    = emit_turn ? end_idx : ss_idx_q;
  assign ss_st2     = emit_turn ? end_st : ss_st_q;
  assign turn_seen2 = turn_seen_q | emit_turn;
  assign emit_trail = fin & turn_seen2 & (ss_idx2 < idx);

  always_comb begin
    d0 = {{2{end_head[15]}}, end_head} - {{2{rs_head_q[15]}}, rs_head_q};
    d1 = (d0 > HalfTurn) ? d0 - FullTurn : d0;
    d2 = (d1 > HalfTurn) ? d1 - FullTurn : d1;
    d3 = (d2 < -HalfTurn) ? d2 + FullTurn : d2;
    d4 = (d3 < -HalfTurn) ? d3 + FullTurn : d3;
    ad = (d4 < 0) ? 18'(-d4) : 18'(d4);
    if (ad > {3'b000, sharp_q}) begin
      turn_kind = KIND_SHARP;
    end else if (ad < {3'b000, wide_q}) begin
      turn_kind = KIND_WIDE;
    end else begin
      turn_kind = KIND_NORMAL;
    end
  end

  always_comb begin
    lead_seg = '{segment_kind: KIND_STRAIGHT, start_index: ss_idx_q, end_index: rs_idx_q,
                 start_station: ss_st_q, end_station: rs_st_q, peak_curvature: '0,
                 last_of_step: 1'b0};
    turn_seg = '{segment_kind: turn_kind, start_index: rs_idx_q, end_index: end_idx,
                 start_station: rs_st_q, end_station: end_st, peak_curvature: best1,
                 last_of_step: 1'b0};
    trail_seg = '{segment_kind: KIND_STRAIGHT, start_index: ss_idx2, end_index: idx,
                  start_station: ss_st2, end_station: in_data_i.arc_length,
                  peak_curvature: '0, last_of_step: 1'b0};
    slot_d = '0;
    n = 2'd0;
    if (emit_lead) begin
      slot_d.seg[n] = lead_seg;
      n = n + 2'd1;
    end
    if (emit_turn) begin
      slot_d.seg[n] = turn_seg;
      n = n + 2'd1;
    end
    if (emit_trail) begin
      slot_d.seg[n] = trail_seg;
      n = n + 2'd1;
    end
    slot_d.cnt = n;
  end

  assign push = in_acc & (n != 2'd0);

  always_comb begin
    point_cnt_d  = point_cnt_q;
    prior_curv_d = prior_curv_q;
    older_mag_d  = older_mag_q;
    prior_head_d = prior_head_q;
    prior_st_d   = prior_st_q;
    run_active_d = run_active_q;
    has_peak_d   = has_peak_q;
    rs_idx_d     = rs_idx_q;
    rs_head_d    = rs_head_q;
    rs_st_d      = rs_st_q;
    best_d       = best_q;
    ss_idx_d     = ss_idx_q;
    ss_st_d      = ss_st_q;
    turn_seen_d  = turn_seen_q;
    if (in_acc) begin
      if (fin) begin
        point_cnt_d  = '0;
        prior_curv_d = '0;
        older_mag_d  = '0;
        prior_head_d = '0;
        prior_st_d   = '0;
        run_active_d = 1'b0;
        has_peak_d   = 1'b0;
        rs_idx_d     = '0;
        rs_head_d    = '0;
        rs_st_d      = '0;
        best_d       = '0;
        ss_idx_d     = '0;
        ss_st_d      = '0;
        turn_seen_d  = 1'b0;
      end else begin
        older_mag_d  = pmag;
        prior_curv_d = in_data_i.curvature;
        prior_head_d = in_data_i.heading;
        prior_st_d   = in_data_i.arc_length;
        if (point_cnt_q != IdxW'(MaxPoints - 1)) begin
          point_cnt_d = point_cnt_q + IdxW'(1);
        end
        run_active_d = open_run | (run_active_q & ~close_early);
        ss_idx_d     = ss_idx2;
        ss_st_d      = ss_st2;
        turn_seen_d  = turn_seen2;
        if (open_run) begin
          has_peak_d = 1'b0;
          best_d     = '0;
          rs_idx_d   = idx;
          rs_head_d  = in_data_i.heading;
          rs_st_d    = in_data_i.arc_length;
        end else begin
          has_peak_d = has_peak1;
          best_d     = best1;
        end
      end
    end
  end

  assign head        = q_mem[rd_ptr_q];
  assign out_valid_o = (fill_q != '0);
  assign in_stall_o  = (fill_q == (QPtrW+1)'(QDepth));
  assign out_last    = (sub_q == head.cnt - 2'd1);
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign pop         = out_acc & out_last;

  always_comb begin
    out_data_o              = head.seg[sub_q];
    out_data_o.last_of_step = out_last;
  end

  always_comb begin
    sub_d = sub_q;
    if (out_acc) begin
      sub_d = out_last ? 2'd0 : sub_q + 2'd1;
    end
    fill_d = fill_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_thr_q   <= PEAK_THRESHOLD_RST;
      run_thr_q    <= RUN_THRESHOLD_RST;
      sharp_q      <= SHARP_ANGLE_RST;
      wide_q       <= WIDE_ANGLE_RST;
      point_cnt_q  <= '0;
      prior_curv_q <= '0;
      older_mag_q  <= '0;
      prior_head_q <= '0;
      prior_st_q   <= '0;
      run_active_q <= 1'b0;
      has_peak_q   <= 1'b0;
      rs_idx_q     <= '0;
      rs_head_q    <= '0;
      rs_st_q      <= '0;
      best_q       <= '0;
      ss_idx_q     <= '0;
      ss_st_q      <= '0;
      turn_seen_q  <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      fill_q       <= '0;
      sub_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PEAK_THRESHOLD: peak_thr_q <= cfg_data_i;
          REG_RUN_THRESHOLD:  run_thr_q  <= cfg_data_i;
          REG_SHARP_ANGLE:    sharp_q    <= cfg_data_i;
          REG_WIDE_ANGLE:     wide_q     <= cfg_data_i;
          default: ;
        endcase
      end
      point_cnt_q  <= point_cnt_d;
      prior_curv_q <= prior_curv_d;
      older_mag_q  <= older_mag_d;
      prior_head_q <= prior_head_d;
      prior_st_q   <= prior_st_d;
      run_active_q <= run_active_d;
      has_peak_q   <= has_peak_d;
      rs_idx_q     <= rs_idx_d;
      rs_head_q    <= rs_head_d;
      rs_st_q      <= rs_st_d;
      best_q       <= best_d;
      ss_idx_q     <= ss_idx_d;
      ss_st_q      <= ss_st_d;
      turn_seen_q  <= turn_seen_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      fill_q <= fill_d;
      sub_q  <= sub_d;
    end
  end

endmodule

// ===== sv/cts_checker.sv =====
`include "curvature_turn_segmenter_unit_defines.svh"

module cts_checker import cts_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `CTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled transaction changed")
  `CTS_ASSERT_NOW(a_straight_flat, out_valid_o && out_data_o.segment_kind == KIND_STRAIGHT, out_data_o.peak_curvature == 16'sd0, "straight carries a peak")
  `CTS_ASSERT_NOW(a_straight_order, out_valid_o && out_data_o.segment_kind == KIND_STRAIGHT, out_data_o.start_index < out_data_o.end_index, "straight with no extent")
  `CTS_ASSERT_NOW(a_turn_peak, out_valid_o && out_data_o.segment_kind != KIND_STRAIGHT, out_data_o.peak_curvature != 16'sd0, "turn without a peak")

endmodule

bind curvature_turn_segmenter_unit cts_checker u_cts_checker (.*);

// ===== test/curvature_turn_segmenter_unit_tb.sv =====
module curvature_turn_segmenter_unit_tb;
  import cts_pkg::*;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 8;
  localparam int          LastIndex   = MaxPoints - 1;
  localparam int          HeadingHalf = 25736;
  localparam int          HeadingFull = 51472;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;

  curvature_turn_segmenter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Segmenter state mirror
  logic [14:0]        thr_peak, thr_run, ang_sharp, ang_wide;
  logic [IdxW-1:0]    pt_count;
  logic signed [15:0] prev_curv;
  logic [14:0]        prev2_mag;
  logic signed [15:0] prev_head;
  logic [23:0]        prev_stn;
  bit                 in_run, run_peaked, had_turn;
  logic [IdxW-1:0]    run_idx;
  logic signed [15:0] run_head;
  logic [23:0]        run_stn;
  logic signed [15:0] peak_curv;
  logic [IdxW-1:0]    str_idx;
  logic [23:0]        str_stn;

  out_item_t step_segs[3];
  int        step_n;
  out_item_t pending_segs[$];
  out_item_t want_seg;

  bit          calm_tail;
  int          mismatches;
  int          points_sent;
  int          segs_predicted;
  int          segs_checked;
  int          config_loads;
  int unsigned cycles;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [14:0] abs_sat(logic signed [15:0] k);
    int v;
    v = int'(k);
    if (v < 0) v = -v;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  function automatic void clear_path();
    pt_count   = '0;
    prev_curv  = '0;
    prev2_mag  = '0;
    prev_head  = '0;
    prev_stn   = '0;
    in_run     = 1'b0;
    run_peaked = 1'b0;
    run_idx    = '0;
    run_head   = '0;
    run_stn    = '0;
    peak_curv  = '0;
    str_idx    = '0;
    str_stn    = '0;
    had_turn   = 1'b0;
  endfunction

  function automatic void add_seg(logic [1:0] kind, int first, int last, logic [23:0] s0,
                                  logic [23:0] s1, logic signed [15:0] peak);
    out_item_t s;
    s.segment_kind   = kind;
    s.start_index    = first[IdxW-1:0];
    s.end_index      = last[IdxW-1:0];
    s.start_station  = s0;
    s.end_station    = s1;
    s.peak_curvature = peak;
    s.last_of_step   = 1'b0;
    step_segs[step_n] = s;
    step_n++;
  endfunction

  function automatic void close_turn(int last, logic signed [15:0] last_head,
                                     logic [23:0] last_stn);
    int h0, h1, turn, mag;
    logic [1:0] kind;
    in_run = 1'b0;
    if (!run_peaked) return;
    if (run_idx > str_idx)
      add_seg(KIND_STRAIGHT, int'(str_idx), int'(run_idx), str_stn, run_stn, '0);
    h1 = int'(last_head);
    h0 = int'(run_head);
    turn = h1 - h0;
    if (turn > HeadingHalf) turn -= HeadingFull;
    if (turn > HeadingHalf) turn -= HeadingFull;
    if (turn < -HeadingHalf) turn += HeadingFull;
    if (turn < -HeadingHalf) turn += HeadingFull;
    mag = turn < 0 ? -turn : turn;
    if (mag > int'(ang_sharp)) kind = KIND_SHARP;
    else if (mag < int'(ang_wide)) kind = KIND_WIDE;
    else kind = KIND_NORMAL;
    add_seg(kind, int'(run_idx), last, run_stn, last_stn, peak_curv);
    str_idx  = last[IdxW-1:0];
    str_stn  = last_stn;
    had_turn = 1'b1;
  endfunction

  function automatic void predict_segments(in_item_t p);
    logic [14:0] k_mag, p_mag;
    int idx;
    k_mag  = abs_sat(p.curvature);
    p_mag  = abs_sat(prev_curv);
    idx    = int'(pt_count);
    step_n = 0;
    // the prior point is a peak once its successor is known
    if (idx >= 2 && in_run && p_mag > thr_peak && p_mag > prev2_mag && p_mag > k_mag) begin
      if (!run_peaked || p_mag > abs_sat(peak_curv)) peak_curv = prev_curv;
      run_peaked = 1'b1;
    end
    if (in_run && k_mag <= thr_run) close_turn(idx - 1, prev_head, prev_stn);
    if (!in_run && k_mag > thr_run) begin
      in_run     = 1'b1;
      run_peaked = 1'b0;
      peak_curv  = '0;
      run_idx    = idx[IdxW-1:0];
      run_head   = p.heading;
      run_stn    = p.arc_length;
    end
    if (p.final_point) begin
      if (in_run) close_turn(idx, p.heading, p.arc_length);
      if (had_turn && int'(str_idx) < idx)
        add_seg(KIND_STRAIGHT, int'(str_idx), idx, str_stn, p.arc_length, '0);
      clear_path();
    end else begin
      prev2_mag = p_mag;
      prev_curv = p.curvature;
      prev_head = p.heading;
      prev_stn  = p.arc_length;
      if (int'(pt_count) < LastIndex) pt_count++;
    end
    if (step_n > 0) step_segs[step_n-1].last_of_step = 1'b1;
    for (int i = 0; i < step_n; i++) pending_segs.insert(pending_segs.size(), step_segs[i]);
    segs_predicted += step_n;
  endfunction

  function automatic string seg_text(out_item_t s);
    return $sformatf("kind %0d idx %0d..%0d stn %0d..%0d peak %0d last %0b", s.segment_kind,
                     s.start_index, s.end_index, s.start_station, s.end_station,
                     s.peak_curvature, s.last_of_step);
  endfunction

  task automatic report_seg(string what, out_item_t got, out_item_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR %s at cycle %0d", what, cycles);
      $display("  got      %s", seg_text(got));
      $display("  expected %s", seg_text(want));
    end
  endtask

  // Compare each segment transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_segs.size() == 0) begin
        report_seg("segment with nothing predicted", out_data, '0);
      end else begin
        want_seg = pending_segs.pop_front();
        segs_checked++;
        if (out_data !== want_seg) report_seg("segment mismatch", out_data, want_seg);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("curvature_turn_segmenter_unit verification failed");
      $finish;
    end
  end

  // Output backpressure in bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm_tail && $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_point(int k, int h, int s, bit fin);
    in_item_t p;
    p.curvature   = k[15:0];
    p.heading     = h[15:0];
    p.arc_length  = s[23:0];
    p.final_point = fin;
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_segments(p);
    points_sent++;
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_config(logic [14:0] pk, logic [14:0] rn, logic [14:0] sh,
                             logic [14:0] wd);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PEAK_THRESHOLD;
    cfg_data  <= pk;
    @(posedge clk);
    cfg_index <= REG_RUN_THRESHOLD;
    cfg_data  <= rn;
    @(posedge clk);
    cfg_index <= REG_SHARP_ANGLE;
    cfg_data  <= sh;
    @(posedge clk);
    cfg_index <= REG_WIDE_ANGLE;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_peak  = pk;
    thr_run   = rn;
    ang_sharp = sh;
    ang_wide  = wd;
    config_loads++;
  endtask

  task automatic random_path(int len);
    int i, k, h, s, v, left, bump_len, peak_at, amp, step, mode;
    bit neg;
    i = 0;
    s = $urandom_range(0, 1000);
    left = 0;
    while (i < len) begin
      if (left == 0) begin
        mode     = $urandom_range(0, 9);
        bump_len = $urandom_range(1, 8);
        left     = bump_len;
        peak_at  = $urandom_range(0, bump_len - 1);
        amp      = $urandom_range(thr_peak, 32768);
        step     = $urandom_range(1, 4000);
        neg      = $urandom_range(0, 1);
      end
      if (mode == 0) begin
        k = $urandom_range(0, 65535) - 32768;
      end else if (mode <= 3) begin
        k = $urandom_range(0, 2 * thr_run) - thr_run;
      end else begin
        v = bump_len - left - peak_at;
        v = amp - (v < 0 ? -v : v) * step;
        if (v < 0) v = 0;
        if (neg ^ ($urandom_range(0, 7) == 0)) k = -v;
        else k = v > 32767 ? 32767 : v;
      end
      if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1) ? HeadingHalf : -HeadingHalf;
      else h = $urandom_range(0, HeadingFull) - HeadingHalf;
      if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 16777215);
      else s += $urandom_range(0, 3000);
      push_point(k, h, s, i == len - 1);
      left--;
      i++;
    end
  endtask

  task automatic test_turn_kinds();
    // normal turn after a leading straight
    push_point(0, 0, 0, 0);
    push_point(0, 100, 40, 0);
    push_point(300, 200, 80, 0);
    push_point(900, 4000, 120, 0);
    push_point(300, 9000, 160, 0);
    push_point(0, 9100, 200, 0);
    // saturated magnitude, equal peaks, heading wrap to a wide turn
    push_point(-300, -HeadingHalf, 240, 0);
    push_point(-32768, -20000, 280, 0);
    push_point(-300, 0, 320, 0);
    push_point(32767, 20000, 360, 0);
    push_point(300, HeadingHalf, 400, 0);
    push_point(0, 0, 440, 0);
    // sharp turn, then trailing straight at the top station
    push_point(2000, 0, 480, 0);
    push_point(-5000, 10000, 520, 0);
    push_point(2000, 20000, 560, 0);
    push_point(0, 0, 600, 0);
    push_point(0, -HeadingHalf, 16777215, 1);
    wait_idle();
  endtask

  task automatic test_path_end();
    // final point closes an open turn
    push_point(0, 0, 0, 0);
    push_point(500, 1000, 10, 0);
    push_point(1000, 2000, 20, 0);
    push_point(500, -3000, 30, 1);
    // final point cannot be a peak
    push_point(0, 0, 0, 0);
    push_point(500, 0, 5, 0);
    push_point(1000, 0, 9, 1);
    push_point(32767, 0, 0, 1);
    wait_idle();
  endtask

  task automatic test_thresholds();
    // peak below the run threshold is dropped
    load_config(15'd100, 15'd1000, SHARP_ANGLE_RST, WIDE_ANGLE_RST);
    push_point(0, 0, 0, 0);
    push_point(500, 0, 1, 0);
    push_point(0, 0, 2, 0);
    push_point(1500, -12000, 3, 0);
    push_point(3000, 0, 4, 0);
    push_point(1500, 12000, 5, 0);
    push_point(0, 0, 6, 0);
    push_point(0, 0, 7, 1);
    wait_idle();
    load_config('0, '0, '0, '0);
    push_point(0, 100, 0, 0);
    push_point(1, 100, 1, 0);
    push_point(2, -100, 2, 0);
    push_point(1, 100, 3, 1);
    wait_idle();
    load_config(15'h7FFF, 15'h7FFF, 15'd25736, 15'h7FFF);
    push_point(-32768, 0, 0, 0);
    push_point(32767, 0, 1, 0);
    push_point(0, 0, 2, 1);
    wait_idle();
    load_config(PEAK_THRESHOLD_RST, RUN_THRESHOLD_RST, SHARP_ANGLE_RST, WIDE_ANGLE_RST);
  endtask

  task automatic test_random_paths();
    int pts0;
    pts0 = points_sent;
    while (points_sent - pts0 < 50) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: load_config(PEAK_THRESHOLD_RST, RUN_THRESHOLD_RST, SHARP_ANGLE_RST,
                         WIDE_ANGLE_RST);
          1: load_config(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                         15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
          default: load_config(15'($urandom_range(0, 3000)), 15'($urandom_range(0, 1500)),
                               15'($urandom_range(0, 25736)),
                               15'($urandom_range(0, 25736)));
        endcase
      end
      random_path($urandom_range(3, 20));
    end
    wait_idle();
  endtask

  task automatic test_steady_stream();
    calm_tail = 1'b1;
    load_config(PEAK_THRESHOLD_RST, RUN_THRESHOLD_RST, SHARP_ANGLE_RST, WIDE_ANGLE_RST);
    repeat (2) random_path($urandom_range(10, 16));
    wait_idle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PEAK_THRESHOLD;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    thr_peak  = PEAK_THRESHOLD_RST;
    thr_run   = RUN_THRESHOLD_RST;
    ang_sharp = SHARP_ANGLE_RST;
    ang_wide  = WIDE_ANGLE_RST;
    clear_path();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_turn_kinds();
    test_path_end();
    test_thresholds();
    test_random_paths();
    test_steady_stream();
    $display("Sent %0d path points over %0d register loads; %0d segments compared.",
             points_sent, config_loads, segs_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("curvature_turn_segmenter_unit verification clean");
    end else begin
      $display("curvature_turn_segmenter_unit verification failed");
    end
    $finish;
  end

endmodule
